// ----- rtl/percent_decoder_macros.svh -----
// Assertion macros for the percent decoder.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef PERCENT_DECODER_MACROS_SVH
`define PERCENT_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked later than the antecedent, disabled during reset.
`define PD_ASSERT_TWO(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ----- rtl/pd_pkg.sv -----
// Package for the percent decoder: character constants, escape phase type,
// command record passed from front to back, and hex helper functions.
`timescale 1ns / 1ps
`default_nettype none

package pd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChW       = 8'h57;
  localparam logic [7:0] CaseBit   = 8'h20;

  // Command queue between front and back.
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdLvlW  = $clog2(CmdDepth + 1);

  // Up to three bytes per command.
  localparam int unsigned CmdBytes = 3;
  localparam int unsigned CmdCntW  = $clog2(CmdBytes + 1);
  localparam int unsigned CmdIdxW  = $clog2(CmdBytes);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CmdCntW-1:0]             cnt;
    logic [CmdBytes-1:0][7:0]       bytes;
    logic                           last;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] low;
    low = c | CaseBit;
    return ((c >= ChZero) && (c <= ChNine)) || ((low >= ChLowA) && (low <= ChLowF));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= ChZero) && (c <= ChNine)) begin
      v = c - ChZero;
    end else begin
      v = (c | CaseBit) - ChW;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pd_front.sv -----
// Front end of the percent decoder: tracks the escape phase and turns accepted
// transactions into commands of up to three bytes. Uses pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output pd_pkg::cmd_t     cmd,
  output logic             cmd_wr
);
  import pd_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  held_digit;
  logic [7:0]  held_digit_next;
  logic        hex;
  logic [7:0]  decoded;

  assign hex     = is_hex(in_byte);
  assign decoded = {hex_value(held_digit), hex_value(in_byte)};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

  always_comb begin
    phase_next      = PH_IDLE;
    held_digit_next = held_digit;
    cmd.cnt         = '0;
    cmd.bytes       = '0;
    cmd.last        = in_last;
    unique case (phase)
      PH_PCT: begin
        if (hex) begin
          if (in_last) begin
            cmd.cnt      = CmdCntW'(2);
            cmd.bytes[0] = ChPercent;
            cmd.bytes[1] = in_byte;
          end else begin
            held_digit_next = in_byte;
            phase_next      = PH_DIGIT;
          end
        end else begin
          cmd.bytes[0] = ChPercent;
          cmd.bytes[1] = in_byte;
          // Breaking '%' starts a new escape unless the string ends here.
          if ((in_byte == ChPercent) && !in_last) begin
            cmd.cnt    = CmdCntW'(1);
            phase_next = PH_PCT;
          end else begin
            cmd.cnt = CmdCntW'(2);
          end
        end
      end
      PH_DIGIT: begin
        if (hex) begin
          cmd.cnt      = CmdCntW'(1);
          cmd.bytes[0] = decoded;
        end else begin
          cmd.bytes[0] = ChPercent;
          cmd.bytes[1] = held_digit;
          cmd.bytes[2] = in_byte;
          if ((in_byte == ChPercent) && !in_last) begin
            cmd.cnt    = CmdCntW'(2);
            phase_next = PH_PCT;
          end else begin
            cmd.cnt = CmdCntW'(3);
          end
        end
      end
      default: begin
        cmd.bytes[0] = in_byte;
        if ((in_byte == ChPercent) && !in_last) begin
          phase_next = PH_PCT;
        end else begin
          cmd.cnt = CmdCntW'(1);
        end
      end
    endcase
  end

  // Drop transactions that only advance the escape.
  assign cmd_wr = accept && (cmd.cnt != '0);

endmodule

`default_nettype wire

// ----- rtl/pd_cmd_fifo.sv -----
// Short command queue between the front and back of the percent decoder.
// Register array of CmdDepth commands; uses pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_cmd_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr,
  input  wire pd_pkg::cmd_t          wr_cmd,
  input  wire logic                  rd,
  output pd_pkg::cmd_t               rd_cmd,
  output logic                       full,
  output logic                       empty,
  output logic [pd_pkg::CmdLvlW-1:0] level
);
  import pd_pkg::*;

  cmd_t               mem [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr;
  logic [CmdPtrW-1:0] rd_ptr;

  assign full   = (level == CmdLvlW'(CmdDepth));
  assign empty  = (level == '0);
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        level <= level + 1'b1;
      end else if (rd && !wr) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pd_back.sv -----
// Back end of the percent decoder: walks the bytes of the head command and
// feeds a one-entry output register. Uses pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pd_pkg::cmd_t head,
  input  wire logic        head_valid,
  output logic             head_rd,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import pd_pkg::*;

  logic [CmdIdxW-1:0] idx;
  logic               ovalid;
  logic               load;
  logic               at_end;
  logic [7:0]         sel_byte;

  assign empty   = !ovalid;
  assign load    = head_valid && (!ovalid || pop);
  assign at_end  = (CmdCntW'(idx) + CmdCntW'(1)) == head.cnt;
  assign head_rd = load && at_end;

  always_comb begin
    unique case (idx)
      CmdIdxW'(0): sel_byte = head.bytes[0];
      CmdIdxW'(1): sel_byte = head.bytes[1];
      CmdIdxW'(2): sel_byte = head.bytes[2];
      default:     sel_byte = head.bytes[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= at_end ? '0 : idx + 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      out_last <= head.last && at_end;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/percent_decoder.sv -----
// Percent decoder: one encoded byte per transaction in, decoded bytes out.
// Throughput: 1 byte per cycle in unless the queue is full, and 1 out while pop
// is high; bytes pass the command queue and then the output register. An
// escape broken late yields up to 3 bytes, drained from a 4-command queue.
// Reset (rst, synchronous): clears the escape phase, queue and output register.
`timescale 1ns / 1ps
`default_nettype none

`include "percent_decoder_macros.svh"

module percent_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import pd_pkg::*;

  cmd_t               wr_cmd;
  cmd_t               head;
  logic               cmd_wr;
  logic               head_rd;
  logic               q_empty;
  logic               accept;
  logic [CmdLvlW-1:0] level;

  assign accept = push && !full;

  pd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .cmd     (wr_cmd),
    .cmd_wr  (cmd_wr)
  );

  pd_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_wr),
    .wr_cmd (wr_cmd),
    .rd     (head_rd),
    .rd_cmd (head),
    .full   (full),
    .empty  (q_empty),
    .level  (level)
  );

  pd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .head_rd    (head_rd),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  `PD_ASSERT_NOW(a_level_bound, 1'b1, level <= CmdLvlW'(CmdDepth), "command queue overflow")
  `PD_ASSERT_NOW(a_no_rd_empty, head_rd, !q_empty, "read from empty command queue")
  `PD_ASSERT_TWO(a_last_emits, accept && in_last && empty && q_empty, !empty, "final byte lost")

endmodule

`default_nettype wire
